>>> src/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    localparam int GRID_SIZE = 4096;
    localparam int FRAC_BITS = 28;
    localparam int IDX_W     = 12;
    localparam int Q_W       = 32;
    localparam int ITER_W    = 16;
    localparam int COUNT_W   = 25;

    localparam logic [IDX_W-1:0] IDX_MAX    = IDX_W'(GRID_SIZE - 1);
    localparam logic [63:0]      ESC_THRESH = 64'd4 << (2 * FRAC_BITS);

    localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
    localparam logic [2:0] REG_REAL_STEP   = 3'd1;
    localparam logic [2:0] REG_IMAG_ORIGIN = 3'd2;
    localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
    localparam logic [2:0] REG_MAX_ITER    = 3'd4;

    localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870885;
    localparam logic [30:0]        RST_REAL_STEP   = 31'd335544;
    localparam logic signed [31:0] RST_IMAG_ORIGIN = 32'sd27;
    localparam logic [30:0]        RST_IMAG_STEP   = 31'd150995;
    localparam logic [15:0]        RST_MAX_ITER    = 16'd2000;

    typedef struct packed {
        logic signed [Q_W-1:0] re;
        logic signed [Q_W-1:0] im;
    } point_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_UPD,
        BK_DONE
    } back_state_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[63:Q_W-1];
        all_zeros = ~|v[63:Q_W-1];
        if (all_ones || all_zeros)
        begin
            sat_q = v[Q_W-1:0];
        end
        else if (v[63])
        begin
            sat_q = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            sat_q = {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

>>> src/mbe_front.sv
`default_nettype none

module mbe_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [11:0]                col_index,
    input  wire logic [11:0]                row_index,
    input  wire logic signed [31:0]         real_origin,
    input  wire logic [30:0]                real_step,
    input  wire logic signed [31:0]         imag_origin,
    input  wire logic [30:0]                imag_step,
    output logic                            push,
    output mbe_pkg::point_t                 push_point,
    input  wire logic                       q_full
);
    import mbe_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [42:0]      re_prod_reg;
    logic [42:0]      im_prod_reg;
    logic [IDX_W-1:0] col_c;
    logic [IDX_W-1:0] row_c;
    logic             accept;
    logic signed [63:0] re_sum;
    logic signed [63:0] im_sum;

    // clamp indexes beyond the grid
    assign col_c = (col_index > IDX_MAX) ? IDX_MAX : col_index;
    assign row_c = (row_index > IDX_MAX) ? IDX_MAX : row_index;

    assign in_stall      = s1_valid_reg && q_full;
    assign accept        = in_valid && !in_stall;
    assign push          = s1_valid_reg && !q_full;
    assign s1_valid_next = accept || (s1_valid_reg && q_full);

    assign re_sum = $signed({21'd0, re_prod_reg}) + 64'(real_origin);
    assign im_sum = $signed({21'd0, im_prod_reg}) + 64'(imag_origin);

    assign push_point.re = sat_q(re_sum);
    assign push_point.im = sat_q(im_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            re_prod_reg <= 43'(col_c) * 43'(real_step);
            im_prod_reg <= 43'(row_c) * 43'(imag_step);
        end
    end

endmodule

`default_nettype wire

>>> src/mbe_queue.sv
`default_nettype none

module mbe_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mbe_pkg::point_t push_point,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output mbe_pkg::point_t      q_point
);
    import mbe_pkg::*;

    point_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_point = slot_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_point;
        end
    end

endmodule

`default_nettype wire

>>> src/mbe_iter.sv
`default_nettype none

module mbe_iter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire mbe_pkg::point_t q_point,
    output logic                 pop,
    input  wire logic [15:0]     limit,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 escaped,
    output logic [15:0]          iterations_used,
    output logic [24:0]          outside_count
);
    import mbe_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [Q_W-1:0] cr_reg;
    logic signed [Q_W-1:0] ci_reg;
    logic signed [Q_W-1:0] zr_reg;
    logic signed [Q_W-1:0] zi_reg;
    logic signed [63:0]    rr_reg;
    logic signed [63:0]    ii_reg;
    logic signed [63:0]    ri_reg;
    logic signed [63:0]    diff_reg;
    logic [ITER_W-1:0]     n_reg;
    logic                  esc_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [COUNT_W-1:0]    total_next;
    logic                  out_valid_reg;
    logic                  out_esc_reg;
    logic [ITER_W-1:0]     out_iter_reg;
    logic [COUNT_W-1:0]    out_count_reg;

    logic signed [63:0] rr_prod;
    logic signed [63:0] ii_prod;
    logic signed [63:0] ri_prod;
    logic [63:0]        mag;
    logic               over;
    logic signed [63:0] nr_wide;
    logic signed [63:0] ni_wide;
    logic               slot_free;
    logic               load_out;

    assign rr_prod = zr_reg * zr_reg;
    assign ii_prod = zi_reg * zi_reg;
    assign ri_prod = zr_reg * zi_reg;

    assign mag  = 64'(unsigned'(rr_reg)) + 64'(unsigned'(ii_reg));
    assign over = (mag > ESC_THRESH);

    assign nr_wide = (diff_reg >>> FRAC_BITS) + 64'(cr_reg);
    assign ni_wide = (ri_reg >>> (FRAC_BITS - 1)) + 64'(ci_reg);

    assign slot_free  = !out_valid_reg || !out_stall;
    assign total_next = total_reg + COUNT_W'(esc_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (n_reg == '0)
                begin
                    state_next = BK_UPD;
                end
                else if (over || (n_reg == limit))
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    state_next = BK_UPD;
                end
            end
            BK_UPD:
            begin
                state_next = BK_MUL;
            end
            BK_DONE:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = q_valid;
            end
            BK_DONE:
            begin
                load_out = slot_free;
            end
            default:
            begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                total_reg     <= total_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cr_reg  <= q_point.re;
                ci_reg  <= q_point.im;
                zr_reg  <= q_point.re;
                zi_reg  <= q_point.im;
                n_reg   <= '0;
                esc_reg <= 1'b0;
            end
            BK_MUL:
            begin
                rr_reg <= rr_prod;
                ii_reg <= ii_prod;
                ri_reg <= ri_prod;
            end
            BK_SUM:
            begin
                diff_reg <= rr_reg - ii_reg;
                esc_reg  <= (n_reg != '0) && over;
            end
            BK_UPD:
            begin
                zr_reg <= sat_q(nr_wide);
                zi_reg <= sat_q(ni_wide);
                n_reg  <= n_reg + ITER_W'(1);
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_esc_reg   <= esc_reg;
            out_iter_reg  <= n_reg;
            out_count_reg <= total_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign escaped         = out_esc_reg;
    assign iterations_used = out_iter_reg;
    assign outside_count   = out_count_reg;

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_counter_core.sv
`default_nettype none

// Channel   Handshake            Payload
// --------  -------------------  -----------------------------------------------
// in        in_valid / in_stall  col_index[11:0], row_index[11:0]
// out       out_valid/out_stall  escaped, iterations_used[15:0], outside_count[24:0]
// cfg       APB write/read       paddr[4:2] selects register, pwdata/prdata 32 bit
//
// From an input transfer into an empty block to out_valid, a point passes the front
// register and the queue; the back loads it, squares c first, runs each z update through
// multiply, subtract/compare and add/saturate, and unloads it into the output register.
// The front maps indexes to c in one registered multiply stage; it and the two-entry
// queue hold up to three points ahead of the back.
// rst_n clears control state and the escape total; registers return to defaults.
// A stalled result holds in the output register while the next point iterates.

module mandelbrot_escape_counter_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [11:0] col_index,
    input  wire logic [11:0] row_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             escaped,
    output logic [15:0]      iterations_used,
    output logic [24:0]      outside_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbe_pkg::*;

    logic signed [31:0] real_origin_reg;
    logic [30:0]        real_step_reg;
    logic signed [31:0] imag_origin_reg;
    logic [30:0]        imag_step_reg;
    logic [15:0]        max_iter_reg;
    logic [15:0]        limit;
    logic               cfg_write;
    logic [2:0]         reg_sel;

    logic   push;
    point_t push_point;
    logic   q_full;
    logic   q_valid;
    point_t q_point;
    logic   pop;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign limit     = (max_iter_reg == 16'd0) ? 16'd1 : max_iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg <= RST_REAL_ORIGIN;
            real_step_reg   <= RST_REAL_STEP;
            imag_origin_reg <= RST_IMAG_ORIGIN;
            imag_step_reg   <= RST_IMAG_STEP;
            max_iter_reg    <= RST_MAX_ITER;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_REAL_ORIGIN: real_origin_reg <= pwdata;
                REG_REAL_STEP:   real_step_reg   <= pwdata[30:0];
                REG_IMAG_ORIGIN: imag_origin_reg <= pwdata;
                REG_IMAG_STEP:   imag_step_reg   <= pwdata[30:0];
                REG_MAX_ITER:    max_iter_reg    <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_REAL_ORIGIN: prdata = real_origin_reg;
            REG_REAL_STEP:   prdata = {1'b0, real_step_reg};
            REG_IMAG_ORIGIN: prdata = imag_origin_reg;
            REG_IMAG_STEP:   prdata = {1'b0, imag_step_reg};
            REG_MAX_ITER:    prdata = {16'd0, max_iter_reg};
            default:         prdata = 32'd0;
        endcase
    end

    mbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .col_index   (col_index),
        .row_index   (row_index),
        .real_origin (real_origin_reg),
        .real_step   (real_step_reg),
        .imag_origin (imag_origin_reg),
        .imag_step   (imag_step_reg),
        .push        (push),
        .push_point  (push_point),
        .q_full      (q_full)
    );

    mbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_point (push_point),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_point    (q_point)
    );

    mbe_iter u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_point         (q_point),
        .pop             (pop),
        .limit           (limit),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .escaped         (escaped),
        .iterations_used (iterations_used),
        .outside_count   (outside_count)
    );

endmodule

`default_nettype wire

>>> test/escape_checker.sv
`timescale 1ns / 1ps

module escape_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [11:0] col_index,
    input  wire logic [11:0] row_index,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        escaped,
    input  wire logic [15:0] iterations_used,
    input  wire logic [24:0] outside_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               pending_points,
    output int               mismatch_count
);
    import mbe_pkg::*;

    localparam logic signed [63:0] Q_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic        escaped;
        logic [15:0] iters;
        logic [24:0] total;
    } point_result_t;

    logic signed [31:0] real_origin_q;
    logic [30:0]        real_step_q;
    logic signed [31:0] imag_origin_q;
    logic [30:0]        imag_step_q;
    logic [15:0]        max_iter_q;
    logic [24:0]        escape_total_q;

    point_result_t pending_results[$];

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic point_result_t iterate_point(input logic [11:0] col,
                                                    input logic [11:0] row);
        logic signed [63:0] c_re;
        logic signed [63:0] c_im;
        logic signed [63:0] z_re;
        logic signed [63:0] z_im;
        logic signed [63:0] sq_re;
        logic signed [63:0] sq_im;
        logic signed [63:0] prod_ri;
        logic [63:0]        mag;
        int                 limit;
        point_result_t      res;
        limit = (max_iter_q == '0) ? 1 : int'(max_iter_q);
        c_re = clamp_q(64'(real_origin_q)
                       + $signed(64'(col)) * $signed(64'(real_step_q)));
        c_im = clamp_q(64'(imag_origin_q)
                       + $signed(64'(row)) * $signed(64'(imag_step_q)));
        z_re = c_re;
        z_im = c_im;
        res.escaped = 1'b0;
        res.iters = limit[15:0];
        res.total = '0;
        for (int n = 1; n <= limit; n++)
        begin
            sq_re = z_re * z_re;
            sq_im = z_im * z_im;
            prod_ri = z_re * z_im;
            z_re = clamp_q(((sq_re - sq_im) >>> FRAC_BITS) + c_re);
            z_im = clamp_q((prod_ri >>> (FRAC_BITS - 1)) + c_im);
            mag = z_re * z_re + z_im * z_im;
            if (mag > ESC_THRESH)
            begin
                res.escaped = 1'b1;
                res.iters = n[15:0];
                break;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            real_origin_q = RST_REAL_ORIGIN;
            real_step_q = RST_REAL_STEP;
            imag_origin_q = RST_IMAG_ORIGIN;
            imag_step_q = RST_IMAG_STEP;
            max_iter_q = RST_MAX_ITER;
            escape_total_q = '0;
            pending_results.delete();
            pending_points = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_REAL_ORIGIN: real_origin_q = pwdata;
                    REG_REAL_STEP:   real_step_q = pwdata[30:0];
                    REG_IMAG_ORIGIN: imag_origin_q = pwdata;
                    REG_IMAG_STEP:   imag_step_q = pwdata[30:0];
                    REG_MAX_ITER:    max_iter_q = pwdata[15:0];
                    default:         ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display({"%0t: unexpected transfer, expected none, ",
                              "actual escaped %0d iterations %0d count %0d"},
                             $time, escaped, iterations_used, outside_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (escaped !== want.escaped)
                    begin
                        mismatch_count++;
                        $display("%0t: escaped mismatch, expected %0d, actual %0d",
                                 $time, want.escaped, escaped);
                    end
                    if (iterations_used !== want.iters)
                    begin
                        mismatch_count++;
                        $display("%0t: iterations_used mismatch, expected %0d, actual %0d",
                                 $time, want.iters, iterations_used);
                    end
                    if (outside_count !== want.total)
                    begin
                        mismatch_count++;
                        $display("%0t: outside_count mismatch, expected %0d, actual %0d",
                                 $time, want.total, outside_count);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = iterate_point(col_index, row_index);
                if (want.escaped)
                begin
                    escape_total_q = escape_total_q + 1'b1;
                end
                want.total = escape_total_q;
                pending_results.push_back(want);
            end
            pending_points = pending_results.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import mbe_pkg::*;

    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         LONG_HOLD    = 500;
    localparam int         SETTLE       = 12;
    localparam int         PHASE_POINTS = 50;
    localparam int         RANDOM_PHASES = 6;
    localparam int         PRESSURE_PHASE = 1;
    localparam int         WILD_PHASE   = 3;
    localparam logic [2:0] REG_SLOT_LAST = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] col_index;
    logic [11:0] row_index;
    logic        out_valid;
    logic        out_stall;
    logic        escaped;
    logic [15:0] iterations_used;
    logic [24:0] outside_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int pending_points;
    int mismatch_count;
    int cycle_count = 0;
    int sender_calm = 0;
    bit long_hold_req = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mandelbrot_escape_counter_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .col_index(col_index),
        .row_index(row_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .escaped(escaped),
        .iterations_used(iterations_used),
        .outside_count(outside_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    escape_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .col_index(col_index),
        .row_index(row_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .escaped(escaped),
        .iterations_used(iterations_used),
        .outside_count(outside_count),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .pending_points(pending_points),
        .mismatch_count(mismatch_count)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int gap;
        int calm;
        calm = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (calm > 0)
                begin
                    calm--;
                    gap = 0;
                end
                else if ($urandom_range(0, 31) == 0)
                begin
                    calm = $urandom_range(20, 80);
                    gap = 0;
                end
                else
                begin
                    gap = idle_gap();
                end
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_point(input logic [11:0] col, input logic [11:0] row);
        int gap;
        if (sender_calm > 0)
        begin
            sender_calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 31) == 0)
        begin
            sender_calm = $urandom_range(10, 40);
            gap = 0;
        end
        else
        begin
            gap = idle_gap();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        col_index <= col;
        row_index <= row;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] slot, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {slot, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_random(input bit wild, input int iter_cap);
        logic [15:0] iters;
        iters = 16'($urandom_range(1, iter_cap));
        if (iter_cap > 8 && $urandom_range(0, 3) == 0)
        begin
            iters = 16'($urandom_range(iter_cap + 1, 400));
        end
        if (wild)
        begin
            write_reg(REG_REAL_ORIGIN, $urandom);
            write_reg(REG_REAL_STEP, $urandom & 32'h7FFF_FFFF);
            write_reg(REG_IMAG_ORIGIN, $urandom);
            write_reg(REG_IMAG_STEP, $urandom & 32'h7FFF_FFFF);
        end
        else
        begin
            write_reg(REG_REAL_ORIGIN, 32'(-603979776 + int'($urandom_range(0, 738197504))));
            write_reg(REG_REAL_STEP, $urandom_range(0, 1 << $urandom_range(8, 18)));
            write_reg(REG_IMAG_ORIGIN, 32'(-402653184 + int'($urandom_range(0, 805306368))));
            write_reg(REG_IMAG_STEP, $urandom_range(0, 1 << $urandom_range(8, 18)));
        end
        write_reg(REG_MAX_ITER, {16'd0, iters});
    endtask

    initial
    begin
        int s;
        int p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        col_index = '0;
        row_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_point(12'd0, 12'd0);
        send_point(12'd4095, 12'd4095);
        send_point(12'd1600, 12'd0);
        send_point(12'd0, 12'd4095);
        send_point(12'd4095, 12'd0);
        send_point(12'd2048, 12'd1024);
        send_point(12'd1234, 12'd567);
        drain();

        // zero limit acts as one; spare slots must not disturb anything
        write_reg(REG_MAX_ITER, 32'd0);
        for (s = REG_MAX_ITER + 1; s <= REG_SLOT_LAST; s++)
        begin
            write_reg(3'(s), $urandom);
        end
        send_point(12'd1600, 12'd0);
        send_point(12'd0, 12'd0);
        drain();

        write_reg(REG_REAL_ORIGIN, 32'h8000_0000);
        write_reg(REG_REAL_STEP, 32'h7FFF_FFFF);
        write_reg(REG_IMAG_ORIGIN, 32'h7FFF_FFFF);
        write_reg(REG_IMAG_STEP, 32'd0);
        write_reg(REG_MAX_ITER, 32'd3);
        send_point(12'd0, 12'd0);
        send_point(12'd4095, 12'd4095);
        send_point(12'd1, 12'd0);
        send_point(12'd2, 12'd7);
        drain();

        write_reg(REG_REAL_ORIGIN, 32'd0);
        write_reg(REG_REAL_STEP, 32'h1000_0000);
        write_reg(REG_IMAG_ORIGIN, 32'd0);
        write_reg(REG_IMAG_STEP, 32'd0);
        write_reg(REG_MAX_ITER, 32'h0000_FFFF);
        send_point(12'd0, 12'd0);
        send_point(12'd1, 12'd0);
        send_point(12'd3, 12'd0);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            program_random(p == WILD_PHASE, (p == PRESSURE_PHASE) ? 8 : 48);
            if (p == PRESSURE_PHASE)
            begin
                long_hold_req = 1'b1;
            end
            repeat (PHASE_POINTS)
            begin
                send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            end
            drain();
        end

        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
